// ===== sv/wav_header_parse_and_payload_stream_defines.svh =====
// assertion macros shared by the rtl
`ifndef WAV_HEADER_PARSE_AND_PAYLOAD_STREAM_DEFINES_SVH
`define WAV_HEADER_PARSE_AND_PAYLOAD_STREAM_DEFINES_SVH

// same-cycle implication, sampled on i_clk, quiet during reset
`define WAVHP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, quiet during reset
`define WAVHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/wavhp_pkg.sv =====
`timescale 1ns / 1ps
package wavhp_pkg;

    localparam logic [31:0] TAG_RIFF    = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE    = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT     = 32'h666d_7420;
    localparam logic [31:0] TAG_DATA    = 32'h6461_7461;
    localparam logic [31:0] FMT_MIN_LEN = 32'd16;
    localparam logic [31:0] TAG_LEN     = 32'd4;
    localparam logic [15:0] BITS_OK     = 16'd16;

    localparam logic [1:0] KIND_ACCEPT  = 2'd0;
    localparam logic [1:0] KIND_REJECT  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_RIFF  = 3'd1;
    localparam logic [2:0] ST_BAD_WAVE  = 3'd2;
    localparam logic [2:0] ST_FMT_SHORT = 3'd3;
    localparam logic [2:0] ST_BAD_FMT   = 3'd4;
    localparam logic [2:0] ST_EARLY_END = 3'd5;

    typedef enum logic [3:0] {
        PH_RIFF    = 4'd0,
        PH_SIZE    = 4'd1,
        PH_WAVE    = 4'd2,
        PH_CKID    = 4'd3,
        PH_CKLEN   = 4'd4,
        PH_FMT     = 4'd5,
        PH_SKIP    = 4'd6,
        PH_PAYLOAD = 4'd7,
        PH_IDLE    = 4'd8
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] byte_count;
        logic [31:0] tag_shift;
        logic [31:0] chunk_length;
        logic [15:0] channels_seen;
        logic [31:0] rate_seen;
        logic [15:0] sample_bits_seen;
        logic [31:0] payload_left;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase: PH_RIFF, byte_count: '0, tag_shift: '0, chunk_length: '0,
        channels_seen: '0, rate_seen: '0, sample_bits_seen: '0, payload_left: '0
    };

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [7:0]  payload_byte;
        logic        last_payload;
        logic [15:0] num_channels;
        logic [31:0] rate_hz;
        logic [15:0] sample_width;
        logic [31:0] data_size;
    } t_result;

    typedef struct packed {
        t_phase phase;
        logic   header_open;
    } t_core_stat;

endpackage

// ===== sv/wavhp_if.sv =====
`timescale 1ns / 1ps
interface wavhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       end_of_file;

    modport source (output valid, output file_byte, output end_of_file, input ready);
    modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface wavhp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic        last_payload;
    logic [15:0] num_channels;
    logic [31:0] rate_hz;
    logic [15:0] sample_width;
    logic [31:0] data_size;

    modport source (
        output valid, output kind, output status, output payload_byte,
        output last_payload, output num_channels, output rate_hz,
        output sample_width, output data_size, input ready
    );
    modport sink (
        input valid, input kind, input status, input payload_byte,
        input last_payload, input num_channels, input rate_hz,
        input sample_width, input data_size, output ready
    );
endinterface

// ===== sv/wavhp_core.sv =====
`timescale 1ns / 1ps
module wavhp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_file_byte,
    input  logic                 i_end_of_file,
    output wavhp_pkg::t_result   o_result,
    output wavhp_pkg::t_core_stat o_stat
);
    import wavhp_pkg::*;

    t_state      r_st;
    t_state      n_st;
    t_result     w_res;
    logic [31:0] w_cnt_inc;
    logic        w_header_open;
    logic        w_good;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= STATE_RESET;
        end else if (i_accept) begin
            r_st <= n_st;
        end
    end

    always_comb begin
        n_st          = r_st;
        w_res         = '0;
        w_cnt_inc     = r_st.byte_count + 32'd1;
        w_header_open = (r_st.phase != PH_PAYLOAD) && (r_st.phase != PH_IDLE);
        w_good        = (r_st.channels_seen != 16'd0) && (r_st.rate_seen != 32'd0)
                        && (r_st.sample_bits_seen == BITS_OK);

        unique case (r_st.phase)
            PH_RIFF, PH_SIZE, PH_WAVE, PH_CKID: begin
                n_st.tag_shift  = {r_st.tag_shift[23:0], i_file_byte};
                n_st.byte_count = w_cnt_inc;
                if (w_cnt_inc >= TAG_LEN) begin
                    n_st.byte_count = '0;
                    unique case (r_st.phase)
                        PH_RIFF: begin
                            if (n_st.tag_shift == TAG_RIFF) begin
                                n_st.phase = PH_SIZE;
                            end else begin
                                w_res.valid  = 1'b1;
                                w_res.kind   = KIND_REJECT;
                                w_res.status = ST_BAD_RIFF;
                                n_st.phase   = PH_IDLE;
                            end
                        end
                        PH_SIZE: begin
                            n_st.phase = PH_WAVE;
                        end
                        PH_WAVE: begin
                            if (n_st.tag_shift == TAG_WAVE) begin
                                n_st.phase = PH_CKID;
                            end else begin
                                w_res.valid  = 1'b1;
                                w_res.kind   = KIND_REJECT;
                                w_res.status = ST_BAD_WAVE;
                                n_st.phase   = PH_IDLE;
                            end
                        end
                        default: begin
                            n_st.chunk_length = '0;
                            n_st.phase        = PH_CKLEN;
                        end
                    endcase
                end
            end
            PH_CKLEN: begin
                // length arrives little-endian, lane picked by byte position
                unique case (r_st.byte_count[1:0])
                    2'd0: n_st.chunk_length[7:0]   = i_file_byte;
                    2'd1: n_st.chunk_length[15:8]  = i_file_byte;
                    2'd2: n_st.chunk_length[23:16] = i_file_byte;
                    default: n_st.chunk_length[31:24] = i_file_byte;
                endcase
                n_st.byte_count = w_cnt_inc;
                if (w_cnt_inc >= TAG_LEN) begin
                    n_st.byte_count = '0;
                    if (r_st.tag_shift == TAG_FMT) begin
                        if (n_st.chunk_length < FMT_MIN_LEN) begin
                            w_res.valid  = 1'b1;
                            w_res.kind   = KIND_REJECT;
                            w_res.status = ST_FMT_SHORT;
                            n_st.phase   = PH_IDLE;
                        end else begin
                            n_st.phase = PH_FMT;
                        end
                    end else if (r_st.tag_shift == TAG_DATA) begin
                        w_res.valid       = 1'b1;
                        w_res.kind        = w_good ? KIND_ACCEPT : KIND_REJECT;
                        w_res.status      = w_good ? ST_OK : ST_BAD_FMT;
                        w_res.data_size   = n_st.chunk_length;
                        n_st.payload_left = n_st.chunk_length;
                        n_st.phase        = (w_good && (n_st.chunk_length != 32'd0))
                                            ? PH_PAYLOAD : PH_IDLE;
                    end else begin
                        n_st.phase = (n_st.chunk_length != 32'd0) ? PH_SKIP : PH_CKID;
                    end
                end
            end
            PH_FMT: begin
                if (r_st.byte_count == 32'd2) begin
                    n_st.channels_seen[7:0] = i_file_byte;
                end else if (r_st.byte_count == 32'd3) begin
                    n_st.channels_seen[15:8] = i_file_byte;
                end else if (r_st.byte_count[31:2] == 30'd1) begin
                    // bytes four to seven carry the rate
                    unique case (r_st.byte_count[1:0])
                        2'd0: n_st.rate_seen[7:0]   = i_file_byte;
                        2'd1: n_st.rate_seen[15:8]  = i_file_byte;
                        2'd2: n_st.rate_seen[23:16] = i_file_byte;
                        default: n_st.rate_seen[31:24] = i_file_byte;
                    endcase
                end else if (r_st.byte_count == 32'd14) begin
                    n_st.sample_bits_seen[7:0] = i_file_byte;
                end else if (r_st.byte_count == 32'd15) begin
                    n_st.sample_bits_seen[15:8] = i_file_byte;
                end
                n_st.byte_count = w_cnt_inc;
                if (w_cnt_inc >= r_st.chunk_length) begin
                    n_st.byte_count = '0;
                    n_st.phase      = PH_CKID;
                end
            end
            PH_SKIP: begin
                n_st.byte_count = w_cnt_inc;
                if (w_cnt_inc >= r_st.chunk_length) begin
                    n_st.byte_count = '0;
                    n_st.phase      = PH_CKID;
                end
            end
            PH_PAYLOAD: begin
                n_st.payload_left  = r_st.payload_left - 32'd1;
                w_res.valid        = 1'b1;
                w_res.kind         = KIND_PAYLOAD;
                w_res.status       = ST_OK;
                w_res.payload_byte = i_file_byte;
                w_res.last_payload = (n_st.payload_left == 32'd0) || i_end_of_file;
                w_res.data_size    = r_st.chunk_length;
                if (n_st.payload_left == 32'd0) begin
                    n_st.phase = PH_IDLE;
                end
            end
            default: begin
                n_st.phase = PH_IDLE;
            end
        endcase

        if (i_end_of_file && w_header_open && !w_res.valid) begin
            w_res.valid  = 1'b1;
            w_res.kind   = KIND_REJECT;
            w_res.status = ST_EARLY_END;
        end

        // format fields as they stand after this byte
        w_res.num_channels = n_st.channels_seen;
        w_res.rate_hz      = n_st.rate_seen;
        w_res.sample_width = n_st.sample_bits_seen;
        w_res.valid        = w_res.valid && i_accept;

        if (i_end_of_file) begin
            n_st = STATE_RESET;
        end
    end

    assign o_result           = w_res;
    assign o_stat.phase       = r_st.phase;
    assign o_stat.header_open = w_header_open;

endmodule

// ===== sv/wav_header_parse_and_payload_stream.sv =====
`timescale 1ns / 1ps
// Parses a WAV file presented one byte per transaction on i_in and emits at most one
// result per byte on o_out: a header accept or reject (with status, the format fields
// of the last fmt chunk and the data chunk size), then one transaction per payload
// byte with last_payload on the final one. A byte with end_of_file set closes the file;
// if the header was still open and that byte gave no result, a reject with the
// ended-early status goes out, and the parser then waits for a new RIFF tag. Every byte
// is handled in the cycle it is accepted, so the block takes one byte per clock; the
// single output register is the only storage between the sides, and i_in.ready is low
// only while that register holds a result that o_out has not taken.
`include "wav_header_parse_and_payload_stream_defines.svh"
module wav_header_parse_and_payload_stream (
    input logic         i_clk,
    input logic         i_rst_n,
    wavhp_in_if.sink    i_in,
    wavhp_out_if.source o_out
);
    import wavhp_pkg::*;

    logic       w_in_ready;
    logic       w_accept;
    t_result    w_res;
    t_core_stat w_stat;
    logic       r_valid;
    t_result    r_res;

    assign w_in_ready = !r_valid || o_out.ready;
    assign w_accept   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    wavhp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_file_byte   (i_in.file_byte),
        .i_end_of_file (i_in.end_of_file),
        .o_result      (w_res),
        .o_stat        (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && w_res.valid) begin
            r_res <= w_res;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.kind         = r_res.kind;
    assign o_out.status       = r_res.status;
    assign o_out.payload_byte = r_res.payload_byte;
    assign o_out.last_payload = r_res.last_payload;
    assign o_out.num_channels = r_res.num_channels;
    assign o_out.rate_hz      = r_res.rate_hz;
    assign o_out.sample_width = r_res.sample_width;
    assign o_out.data_size    = r_res.data_size;

    `WAVHP_ASSERT_NEXT(a_eof_restart, w_accept && i_in.end_of_file, w_stat.phase == PH_RIFF, "parser did not restart after end of file")
    `WAVHP_ASSERT_NOW(a_payload_ok, o_out.valid && (o_out.kind == KIND_PAYLOAD), (o_out.status == ST_OK) && (o_out.data_size != 32'd0), "payload transaction with bad status or size")
    `WAVHP_ASSERT_NOW(a_stall_blocks, o_out.valid && !o_out.ready, !i_in.ready, "input taken while result is stalled")
    `WAVHP_ASSERT_NOW(a_early_end, w_accept && i_in.end_of_file && w_stat.header_open, w_res.valid, "ended-early reject was not produced")

endmodule
